FILE: rtl/pfr_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pfr_pkg
// Shared types and constants for the multichannel PWM fade ramp.
// ----------------------------------------------------------------------------
package pfr_pkg;

  // Number of fade channels held in state.
  localparam int Channels = 8;
  // The channel field is three bits wide, so at most eight channels are walked.
  localparam int Lanes    = (Channels < 8) ? Channels : 8;
  localparam int ChIdxW   = (Channels > 1) ? $clog2(Channels) : 1;
  localparam int CntW     = $clog2(Lanes + 1);

  localparam int ChW      = 3;
  localparam int LevelW   = 8;
  localparam int SpeedW   = 3;
  localparam int ActionW  = 2;
  localparam int CipW     = 4;

  localparam logic [SpeedW-1:0] MaxSpeed = 3'd5;

  // APB register map
  localparam int AddrW    = 3;
  localparam int DataW    = 32;
  localparam int RegIdxW  = AddrW - 2;
  localparam logic [RegIdxW-1:0] RegChannelsInUse = '0;

  typedef enum logic [ActionW-1:0] {
    ACT_TICK = 2'd0,
    ACT_FADE = 2'd1,
    ACT_SET  = 2'd2,
    ACT_NONE = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE  = 3'b001,
    ST_SCAN  = 3'b010,
    ST_FLUSH = 3'b100
  } state_t;

endpackage : pfr_pkg
`default_nettype wire

FILE: rtl/pwm_fade_ramp_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// pwm_fade_ramp_core
// Multichannel PWM brightness fader with per-channel slew limiting.
// ----------------------------------------------------------------------------
// A fade or set command on the slave stream (kind in s_tuser) updates one
// channel's goal and speed. A tick walks the channels in use one per cycle,
// unless a waiting result stalls it, through a single shared step unit
// (compare, subtract, shift and add), moves each channel whose level differs
// from its goal one step, and emits one (channel, level) transaction per
// changed channel, the final one with tlast set. A tick keeps s_tready low
// while it walks the channels in use (channels_in_use, capped at eight) and
// flushes its final result, including while the master side holds tready low
// with a result waiting. The walk is bounded by the one step unit.
// ----------------------------------------------------------------------------
module pwm_fade_ramp_core (
  input  wire logic        clk,
  input  wire logic        rst,
  // slave stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [15:0] s_tdata,   // [2:0] channel, [10:3] target, [13:11] speed
  input  wire logic [1:0]  s_tuser,   // [1:0] action
  // master stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [15:0]      m_tdata,   // [2:0] channel_res, [10:3] level
  output logic             m_tlast,
  // APB configuration
  input  wire logic                        psel,
  input  wire logic                        penable,
  input  wire logic                        pwrite,
  input  wire logic [pfr_pkg::AddrW-1:0]   paddr,
  input  wire logic [pfr_pkg::DataW-1:0]   pwdata,
  output logic      [pfr_pkg::DataW-1:0]   prdata,
  output logic                             pready
);

  // channel state
  logic [pfr_pkg::LevelW-1:0] level_q [pfr_pkg::Channels];
  logic [pfr_pkg::LevelW-1:0] goal_q  [pfr_pkg::Channels];
  logic [pfr_pkg::SpeedW-1:0] rate_q  [pfr_pkg::Channels];
  logic [pfr_pkg::CipW-1:0]   channels_in_use;

  pfr_pkg::state_t            state;
  logic [pfr_pkg::CntW-1:0]   cnt;
  logic [pfr_pkg::CntW-1:0]   limit;

  // result waiting to learn whether it is the last of the tick
  logic                       pend_valid;
  logic [pfr_pkg::ChW-1:0]    pend_ch;
  logic [pfr_pkg::LevelW-1:0] pend_level;

  logic [pfr_pkg::ChW-1:0]    out_ch;
  logic [pfr_pkg::LevelW-1:0] out_level;

  // command decode
  pfr_pkg::action_t           in_action;
  logic [pfr_pkg::ChW-1:0]    in_ch;
  logic [pfr_pkg::LevelW-1:0] in_target;
  logic [pfr_pkg::SpeedW-1:0] in_speed;
  logic                       in_hit;
  logic                       in_ch_ok;
  logic [pfr_pkg::ChIdxW-1:0] in_idx;

  // shared step unit
  logic [pfr_pkg::ChIdxW-1:0] ci;
  logic [pfr_pkg::LevelW-1:0] cur;
  logic [pfr_pkg::LevelW-1:0] gl;
  logic [pfr_pkg::SpeedW-1:0] rt;
  logic                       down;
  logic [pfr_pkg::LevelW-1:0] diff;
  logic [pfr_pkg::LevelW-1:0] inc;
  logic [pfr_pkg::LevelW-1:0] step;
  logic [pfr_pkg::LevelW-1:0] nxt;
  logic                       changed;

  logic                       out_free;
  logic                       out_load;
  logic                       scan_done;
  logic                       stall;
  logic                       cfg_wr;
  logic [pfr_pkg::RegIdxW-1:0] reg_idx;

  assign s_tready  = (state == pfr_pkg::ST_IDLE);
  assign in_hit    = s_tvalid && s_tready;
  assign in_action = pfr_pkg::action_t'(s_tuser);
  assign in_ch     = s_tdata[2:0];
  assign in_target = s_tdata[10:3];
  assign in_speed  = s_tdata[13:11];
  assign in_ch_ok  = (32'(in_ch) < 32'(pfr_pkg::Channels));
  assign in_idx    = pfr_pkg::ChIdxW'(in_ch);

  assign m_tdata   = {5'd0, out_level, out_ch};

  // APB
  assign pready  = 1'b1;
  assign reg_idx = paddr[pfr_pkg::AddrW-1:2];
  assign cfg_wr  = psel && penable && pwrite && pready;
  assign prdata  = (reg_idx == pfr_pkg::RegChannelsInUse)
                 ? {{(pfr_pkg::DataW-pfr_pkg::CipW){1'b0}}, channels_in_use}
                 : '0;

  assign limit = (32'(channels_in_use) > pfr_pkg::Lanes)
               ? pfr_pkg::CntW'(pfr_pkg::Lanes)
               : pfr_pkg::CntW'(channels_in_use);

  always_comb begin
    ci      = pfr_pkg::ChIdxW'(cnt);
    cur     = level_q[ci];
    gl      = goal_q[ci];
    rt      = rate_q[ci];
    down    = cur > gl;
    diff    = down ? (cur - gl) : (gl - cur);
    inc     = pfr_pkg::LevelW'(9'd1 << (rt - 3'd1));
    step    = (diff < inc) ? 8'd1 : inc;
    changed = (cur != gl);
    if (rt == '0) begin
      nxt = gl;
    end else if (down) begin
      nxt = cur - step;
    end else begin
      nxt = cur + step;
    end
  end

  assign out_free  = !m_tvalid || m_tready;
  assign scan_done = !(cnt < limit);
  assign stall     = !scan_done && changed && pend_valid && !out_free;
  assign out_load  = ((state == pfr_pkg::ST_SCAN) && !scan_done && changed && !stall
                      && pend_valid)
                   || ((state == pfr_pkg::ST_FLUSH) && pend_valid && out_free);

  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= pfr_pkg::ST_IDLE;
      cnt             <= '0;
      pend_valid      <= 1'b0;
      m_tvalid        <= 1'b0;
      m_tlast         <= 1'b0;
      channels_in_use <= '0;
      for (int i = 0; i < pfr_pkg::Channels; i++) begin
        level_q[i] <= '0;
        goal_q[i]  <= '0;
        rate_q[i]  <= '0;
      end
    end else begin
      if (cfg_wr && reg_idx == pfr_pkg::RegChannelsInUse) begin
        channels_in_use <= pwdata[pfr_pkg::CipW-1:0];
      end
      // load the next result, else drop a taken one
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      unique case (state)
        pfr_pkg::ST_IDLE: begin
          if (in_hit) begin
            unique case (in_action)
              pfr_pkg::ACT_TICK: begin
                state      <= pfr_pkg::ST_SCAN;
                cnt        <= '0;
                pend_valid <= 1'b0;
              end
              pfr_pkg::ACT_FADE: begin
                if (in_ch_ok && in_speed <= pfr_pkg::MaxSpeed) begin
                  goal_q[in_idx] <= in_target;
                  rate_q[in_idx] <= in_speed;
                end
              end
              pfr_pkg::ACT_SET: begin
                if (in_ch_ok) begin
                  goal_q[in_idx] <= in_target;
                  rate_q[in_idx] <= '0;
                end
              end
              default: begin
              end
            endcase
          end
        end
        pfr_pkg::ST_SCAN: begin
          if (scan_done) begin
            state <= pfr_pkg::ST_FLUSH;
          end else if (!changed) begin
            cnt <= cnt + 1'b1;
          end else if (!stall) begin
            level_q[ci] <= nxt;
            pend_ch     <= pfr_pkg::ChW'(cnt);
            pend_level  <= nxt;
            pend_valid  <= 1'b1;
            cnt         <= cnt + 1'b1;
            // a later change means the held result is not the last one
            if (pend_valid) begin
              m_tlast   <= 1'b0;
              out_ch    <= pend_ch;
              out_level <= pend_level;
            end
          end
        end
        pfr_pkg::ST_FLUSH: begin
          if (!pend_valid) begin
            state <= pfr_pkg::ST_IDLE;
          end else if (out_free) begin
            m_tlast    <= 1'b1;
            out_ch     <= pend_ch;
            out_level  <= pend_level;
            pend_valid <= 1'b0;
            state      <= pfr_pkg::ST_IDLE;
          end
        end
        default: begin
          state <= pfr_pkg::ST_IDLE;
        end
      endcase
    end
  end

`ifndef SYNTHESIS
  a_idle_no_pending: assert property (@(posedge clk) disable iff (rst)
    (state == pfr_pkg::ST_IDLE) |-> !pend_valid)
    else $error("pending result left over in idle");

  a_cnt_bounded: assert property (@(posedge clk) disable iff (rst)
    (state == pfr_pkg::ST_SCAN) |-> (cnt <= limit))
    else $error("scan counter past channel limit");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    (state == pfr_pkg::ST_SCAN && stall) |=> ($stable(cnt) && pend_valid))
    else $error("scan advanced while output was blocked");

  a_flush_last: assert property (@(posedge clk) disable iff (rst)
    (state == pfr_pkg::ST_FLUSH && pend_valid && out_free)
      |=> (state == pfr_pkg::ST_IDLE && m_tvalid && m_tlast))
    else $error("final result of tick not marked last");
`endif

endmodule : pwm_fade_ramp_core
`default_nettype wire
